FILE: design/ggx_normal_sampling_assert.svh
// assertion macros for the ggx normal sampling block
// needs a clk and a rst signal in the scope where it is used
`ifndef GGX_NORMAL_SAMPLING_ASSERT_SVH
`define GGX_NORMAL_SAMPLING_ASSERT_SVH

// implication checked at every rising edge, off while reset is high
`define GNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold in the cycle after its trigger, off while reset is high
`define GNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gns_pkg.sv
// constants, types and helper functions for the ggx normal sampling block
// no dependencies
package gns_pkg;

  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned SQRT_STEPS   = 31;
  // trig result is ready at stage 22, the sqrt results at stage 67
  localparam int unsigned TRIG_DELAY   = 45;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [14:0] MAG_MAX     = 15'd32767;
  localparam logic [15:0] ROUGH_RESET = 16'd8192;

  // divisors of the horner steps, innermost term first
  localparam logic [7:0] SIN_K [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_K [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [30:0] s;
    logic [30:0] c;
    quad_t       quad;
  } trig_t;

  // 1.0 - v in q2.30, floored at zero
  function automatic logic [30:0] one_minus(input logic [31:0] v);
    logic [30:0] r;
    if (v >= {1'b0, ONE_Q30}) begin
      r = '0;
    end else begin
      r = ONE_Q30 - v[30:0];
    end
    return r;
  endfunction

  // round at bit 46 and clamp to the magnitude limit
  function automatic logic [14:0] round_sat46(input logic [61:0] v);
    logic [62:0] t;
    logic [16:0] r;
    t = {1'b0, v} + (63'd1 << 45);
    r = t[62:46];
    return (r > 17'(MAG_MAX)) ? MAG_MAX : r[14:0];
  endfunction

  function automatic logic [15:0] apply_sign(input logic [14:0] mag, input logic neg);
    return neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
  endfunction

endpackage

FILE: design/ggx_normal_sampling.sv
// ggx microfacet normal sampling, deep pipeline with output skid stage
// depends on gns_pkg and ggx_normal_sampling_assert.svh

// Takes one sample (u_azimuth, u_polar) per cycle and returns one unit
// microfacet normal (normal_x, normal_y, normal_z) in q1.15 for the ggx
// roughness held in the roughness register (q2.14, reset 0.5). The
// pipeline accepts one item every cycle as long as the output side takes
// results. Most of the pipeline depth is the 32-stage restoring divider
// that forms tan^2 / (1 + tan^2) and the 31-stage square root after it;
// the azimuth sine and cosine come from an 18-stage horner pipeline
// running beside them. A skid register behind the last stage lets one
// more item in while a result waits. Write roughness only while no item
// is in flight.
module ggx_normal_sampling (
  input  logic        clk,
  input  logic        rst,
  input  logic        roughness_wr_en,
  input  logic [15:0] roughness_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // u_azimuth[15:0], u_polar[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // normal_x[15:0], normal_y[31:16], normal_z[46:32], zero pad
);

  localparam int unsigned LAST = 69;

  logic [15:0]   roughness;
  logic [LAST:1] vld;
  logic          en;

  // output register and skid stage
  logic        ov, sv;
  logic [47:0] od, sd;
  logic [47:0] ld;
  logic        lv_fire;

  assign en            = !sv;
  assign s_axis_tready = en;
  assign lv_fire       = vld[LAST] && !sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      roughness <= gns_pkg::ROUGH_RESET;
    end else if (roughness_wr_en) begin
      roughness <= roughness_wr_data;
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], s_axis_tvalid};
    end
  end

  // stage 1: capture sample, square roughness
  logic [15:0] p1, az1;
  logic [31:0] a2_1;
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= s_axis_tdata[31:16];
      az1  <= s_axis_tdata[15:0];
      a2_1 <= 32'(roughness) * 32'(roughness);
    end
  end

  // stage 2: numerator and 1 - u, both scaled by 2^-12 against the exact form
  logic [47:0] num2;
  logic [44:0] one2;
  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= 48'(a2_1) * 48'(p1);
      one2 <= 45'(17'h1_0000 - {1'b0, p1}) << 28;
    end
  end

  // stage 3: denominator
  logic [48:0] den3, num3;
  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= 49'(num2) + 49'(one2);
      num3 <= 49'(num2);
    end
  end

  // divider: q = floor(num * 2^32 / den), one quotient bit a stage
  logic [48:0] dv_rem [gns_pkg::DIV_STEPS+1];
  logic [48:0] dv_den [gns_pkg::DIV_STEPS+1];
  logic [31:0] dv_q   [gns_pkg::DIV_STEPS+1];
  assign dv_rem[0] = num3;
  assign dv_den[0] = den3;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < gns_pkg::DIV_STEPS; k++) begin : g_div
    logic [49:0] r2;
    assign r2 = {dv_rem[k], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[k+1] <= dv_den[k];
        if (r2 >= {1'b0, dv_den[k]}) begin
          dv_rem[k+1] <= 49'(r2 - {1'b0, dv_den[k]});
          dv_q[k+1]   <= {dv_q[k][30:0], 1'b1};
        end else begin
          dv_rem[k+1] <= r2[48:0];
          dv_q[k+1]   <= {dv_q[k][30:0], 1'b0};
        end
      end
    end
  end

  // stage 36: cos^2 follows from the same quotient, 2^32 - ceil(quotient)
  logic [31:0] c2_36, s2_36;
  logic [32:0] c2_full;
  logic [31:0] q_fin;
  logic        rem_nz;
  assign q_fin   = dv_q[gns_pkg::DIV_STEPS];
  assign rem_nz  = dv_rem[gns_pkg::DIV_STEPS] != '0;
  assign c2_full = 33'h1_0000_0000 - {1'b0, q_fin} - {32'd0, rem_nz};
  always_ff @(posedge clk) begin
    if (en) begin
      s2_36 <= q_fin;
      c2_36 <= c2_full[32] ? 32'hFFFF_FFFF : c2_full[31:0];
    end
  end

  // square roots of c2 << 30 and s2 << 30, one result bit a stage
  logic [62:0] sc_v [gns_pkg::SQRT_STEPS+1];
  logic [62:0] sc_r [gns_pkg::SQRT_STEPS+1];
  logic [62:0] sn_v [gns_pkg::SQRT_STEPS+1];
  logic [62:0] sn_r [gns_pkg::SQRT_STEPS+1];
  assign sc_v[0] = {1'b0, c2_36, 30'd0};
  assign sn_v[0] = {1'b0, s2_36, 30'd0};
  assign sc_r[0] = '0;
  assign sn_r[0] = '0;

  for (genvar i = 0; i < gns_pkg::SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'd1 << (60 - 2 * i);
    logic [62:0] tc, ts;
    assign tc = sc_r[i] + BIT;
    assign ts = sn_r[i] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sc_v[i] >= tc) begin
          sc_v[i+1] <= sc_v[i] - tc;
          sc_r[i+1] <= (sc_r[i] >> 1) + BIT;
        end else begin
          sc_v[i+1] <= sc_v[i];
          sc_r[i+1] <= sc_r[i] >> 1;
        end
        if (sn_v[i] >= ts) begin
          sn_v[i+1] <= sn_v[i] - ts;
          sn_r[i+1] <= (sn_r[i] >> 1) + BIT;
        end else begin
          sn_v[i+1] <= sn_v[i];
          sn_r[i+1] <= sn_r[i] >> 1;
        end
      end
    end
  end

  // azimuth: stage 2 angle in radians q1.30, stage 3 its square
  logic [30:0]    x2s;
  logic [31:0]    xx3;
  logic [30:0]    x3;
  gns_pkg::quad_t qd2, qd3;
  logic [60:0]    xprod;
  logic [61:0]    sqprod;
  assign xprod  = 61'({az1[13:0], 16'd0}) * 61'(gns_pkg::HALF_PI_Q30);
  assign sqprod = 62'(x2s) * 62'(x2s);
  always_ff @(posedge clk) begin
    if (en) begin
      x2s <= xprod[60:30];
      qd2 <= gns_pkg::quad_t'(az1[15:14]);
      x3  <= x2s;
      xx3 <= sqprod[61:30];
      qd3 <= qd2;
    end
  end

  // horner steps, three stages each: multiply, reciprocal, correct
  logic [30:0]    hb_s [gns_pkg::HORNER_STEPS+1];
  logic [30:0]    hb_c [gns_pkg::HORNER_STEPS+1];
  logic [30:0]    hx   [gns_pkg::HORNER_STEPS+1];
  logic [31:0]    hx2  [gns_pkg::HORNER_STEPS+1];
  gns_pkg::quad_t hq   [gns_pkg::HORNER_STEPS+1];
  assign hb_s[0] = gns_pkg::ONE_Q30;
  assign hb_c[0] = gns_pkg::ONE_Q30;
  assign hx[0]   = x3;
  assign hx2[0]  = xx3;
  assign hq[0]   = qd3;

  for (genvar j = 0; j < gns_pkg::HORNER_STEPS; j++) begin : g_horner
    localparam logic [7:0]  KS = gns_pkg::SIN_K[j];
    localparam logic [7:0]  KC = gns_pkg::COS_K[j];
    localparam logic [32:0] MS = 33'((64'd1 << 33) / KS);
    localparam logic [32:0] MC = 33'((64'd1 << 33) / KC);
    logic [31:0]    ta_s, ta_c, tb_s, tb_c, qb_s, qb_c;
    logic [30:0]    xa, xb;
    logic [31:0]    x2a, x2b;
    gns_pkg::quad_t qa, qb;
    logic [61:0]    pa_s, pa_c;
    logic [64:0]    pb_s, pb_c;
    logic [32:0]    rm_s, rm_c;
    logic [31:0]    qc_s, qc_c;
    assign pa_s = 62'(hx2[j]) * 62'(hb_s[j]);
    assign pa_c = 62'(hx2[j]) * 62'(hb_c[j]);
    assign pb_s = 65'(ta_s) * 65'(MS);
    assign pb_c = 65'(ta_c) * 65'(MC);
    // the reciprocal estimate is low by at most one
    assign rm_s = {1'b0, tb_s} - 33'(qb_s) * 33'(KS);
    assign rm_c = {1'b0, tb_c} - 33'(qb_c) * 33'(KC);
    assign qc_s = qb_s + {31'd0, rm_s >= 33'(KS)};
    assign qc_c = qb_c + {31'd0, rm_c >= 33'(KC)};
    always_ff @(posedge clk) begin
      if (en) begin
        ta_s      <= pa_s[61:30];
        ta_c      <= pa_c[61:30];
        xa        <= hx[j];
        x2a       <= hx2[j];
        qa        <= hq[j];
        tb_s      <= ta_s;
        tb_c      <= ta_c;
        qb_s      <= pb_s[64:33];
        qb_c      <= pb_c[64:33];
        xb        <= xa;
        x2b       <= x2a;
        qb        <= qa;
        hb_s[j+1] <= gns_pkg::one_minus(qc_s);
        hb_c[j+1] <= gns_pkg::one_minus(qc_c);
        hx[j+1]   <= xb;
        hx2[j+1]  <= x2b;
        hq[j+1]   <= qb;
      end
    end
  end

  // stage 22: sine gets its last factor of x, then wait for the polar path
  gns_pkg::trig_t tdl [gns_pkg::TRIG_DELAY+1];
  logic [61:0]    sprod;
  assign sprod = 62'(hx[gns_pkg::HORNER_STEPS]) * 62'(hb_s[gns_pkg::HORNER_STEPS]);
  always_ff @(posedge clk) begin
    if (en) begin
      tdl[0].s    <= sprod[60:30];
      tdl[0].c    <= hb_c[gns_pkg::HORNER_STEPS];
      tdl[0].quad <= hq[gns_pkg::HORNER_STEPS];
    end
  end
  for (genvar d = 0; d < gns_pkg::TRIG_DELAY; d++) begin : g_tdl
    always_ff @(posedge clk) begin
      if (en) begin
        tdl[d+1] <= tdl[d];
      end
    end
  end

  // stage 68: rotate by quadrant and scale by sin(theta)
  gns_pkg::trig_t tr;
  logic [30:0]    cp, sp, sin_t, cos_t;
  logic           cneg, sneg;
  assign tr    = tdl[gns_pkg::TRIG_DELAY];
  assign sin_t = sn_r[gns_pkg::SQRT_STEPS][30:0];
  assign cos_t = sc_r[gns_pkg::SQRT_STEPS][30:0];
  always_comb begin
    case (tr.quad)
      gns_pkg::QUAD_0: begin cp = tr.c; cneg = 1'b0; sp = tr.s; sneg = 1'b0; end
      gns_pkg::QUAD_1: begin cp = tr.s; cneg = 1'b1; sp = tr.c; sneg = 1'b0; end
      gns_pkg::QUAD_2: begin cp = tr.c; cneg = 1'b1; sp = tr.s; sneg = 1'b1; end
      default:         begin cp = tr.s; cneg = 1'b0; sp = tr.c; sneg = 1'b1; end
    endcase
  end

  logic [61:0] px, py;
  logic [30:0] cz;
  logic        nx_neg, ny_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      px     <= 62'(sin_t) * 62'(cp);
      py     <= 62'(sin_t) * 62'(sp);
      cz     <= cos_t;
      nx_neg <= cneg;
      ny_neg <= sneg;
    end
  end

  // stage 69: round, clamp, sign
  logic [16:0] zr;
  logic [14:0] nz;
  assign zr = 17'((32'(cz) + 32'h8000) >> 16);
  assign nz = (zr > 17'(gns_pkg::MAG_MAX)) ? gns_pkg::MAG_MAX : zr[14:0];
  always_ff @(posedge clk) begin
    if (en) begin
      ld <= {1'b0, nz,
             gns_pkg::apply_sign(gns_pkg::round_sat46(py), ny_neg),
             gns_pkg::apply_sign(gns_pkg::round_sat46(px), nx_neg)};
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || m_axis_tready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= lv_fire;
      end
    end else if (lv_fire) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || m_axis_tready) begin
      od <= sv ? sd : ld;
    end else if (lv_fire) begin
      sd <= ld;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = od;

`include "ggx_normal_sampling_assert.svh"

  `GNS_ASSERT(a_skid_behind_out, sv |-> ov, "skid holds an item while output is empty")
  `GNS_ASSERT_NEXT(a_skid_fills, ov && !m_axis_tready && lv_fire, sv, "stalled item lost")
  `GNS_ASSERT(a_out_source, $rose(ov) |-> $past(vld[LAST] || sv), "result without source item")

endmodule

FILE: tb/ggx_normal_sampling_tb.sv
// testbench for ggx_normal_sampling: streams samples, predicts each normal
// with a bit-exact fixed-point model and checks results in order; uses gns_pkg
`timescale 1ns / 1ps

module ggx_normal_sampling_tb;

  localparam int unsigned PIPE_LAT = 70;

  typedef struct packed {
    logic [15:0] u_polar;
    logic [15:0] u_azimuth;
  } sample_t;

  typedef struct packed {
    logic [15:0] nz;  // zero padded normal_z
    logic [15:0] ny;
    logic [15:0] nx;
  } normal_t;

  logic        clk;
  logic        rst;
  logic        roughness_wr_en;
  logic [15:0] roughness_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // u_azimuth[15:0], u_polar[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // normal_x[15:0], normal_y[31:16], normal_z[46:32]

  ggx_normal_sampling u_top (
    .clk              (clk),
    .rst              (rst),
    .roughness_wr_en  (roughness_wr_en),
    .roughness_wr_data(roughness_wr_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  // predictor copy of the roughness register
  logic [15:0] alpha_q;
  sample_t     sample_q[$];
  normal_t     normal_q[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          err_cnt;
  int          got_cnt;
  int          sent_cnt;

  // floor(n * 2^32 / d), saturated
  function automatic logic [63:0] div_frac(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = n;
    if (d == 0) return 0;
    if (n >= d) return 64'hFFFF_FFFF;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] q30_sub1(input logic [63:0] v);
    return (v >= 64'(gns_pkg::ONE_Q30)) ? 64'd0 : 64'(gns_pkg::ONE_Q30) - v;
  endfunction

  function automatic logic [14:0] mag_round(input logic [63:0] v, input int sh);
    logic [63:0] r;
    r = (v + (64'd1 << (sh - 1))) >> sh;
    return (r > 64'(gns_pkg::MAG_MAX)) ? gns_pkg::MAG_MAX : r[14:0];
  endfunction

  function automatic normal_t ggx_normal(input sample_t smp, input logic [15:0] alpha);
    int unsigned sdiv [6] = '{156, 110, 72, 42, 20, 6};
    int unsigned cdiv [6] = '{132, 90, 56, 30, 12, 2};
    logic [63:0] ua, up, num, one, den, cos_t, sin_t, x, x2, bs, bc, cp, sp;
    logic        cneg, sneg;
    gns_pkg::quad_t quad;
    logic [14:0] mx, my;
    normal_t     o;
    ua = 64'(smp.u_azimuth) << 16;
    up = 64'(smp.u_polar) << 16;
    num = ((64'(alpha) * 64'(alpha)) * up) >> 4;
    one = ((64'd1 << 32) - up) << 24;
    den = one + num;
    o = '0;
    if (den == 0) begin
      o.nz = 16'(gns_pkg::MAG_MAX);
      return o;
    end
    cos_t = int_sqrt(div_frac(one, den) << 30);
    sin_t = int_sqrt(div_frac(num, den) << 30);
    quad = gns_pkg::quad_t'(ua[31:30]);
    x = ((ua & (64'(gns_pkg::ONE_Q30) - 1)) * 64'(gns_pkg::HALF_PI_Q30)) >> 30;
    x2 = q30_mul(x, x);
    bs = 64'(gns_pkg::ONE_Q30);
    bc = 64'(gns_pkg::ONE_Q30);
    for (int i = 0; i < 6; i++) begin
      bs = q30_sub1(q30_mul(x2, bs) / sdiv[i]);
      bc = q30_sub1(q30_mul(x2, bc) / cdiv[i]);
    end
    bs = q30_mul(x, bs);
    // quadrant rotates the sine/cosine pair
    case (quad)
      gns_pkg::QUAD_0: begin cp = bc; cneg = 0; sp = bs; sneg = 0; end
      gns_pkg::QUAD_1: begin cp = bs; cneg = 1; sp = bc; sneg = 0; end
      gns_pkg::QUAD_2: begin cp = bc; cneg = 1; sp = bs; sneg = 1; end
      default: begin cp = bs; cneg = 0; sp = bc; sneg = 1; end
    endcase
    mx = mag_round(sin_t * cp, 46);
    my = mag_round(sin_t * sp, 46);
    // a negated zero stays zero
    o.nx = cneg ? 16'd0 - {1'b0, mx} : {1'b0, mx};
    o.ny = sneg ? 16'd0 - {1'b0, my} : {1'b0, my};
    o.nz = {1'b0, mag_round(cos_t, 16)};
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: presents queued samples, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        normal_q.push_back(ggx_normal(sample_t'(s_axis_tdata), alpha_q));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= sample_q.pop_front();
          s_axis_tvalid <= 1;
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor: random back pressure and in-order compare
  always @(posedge clk) begin
    normal_t got;
    normal_t exp_n;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = normal_t'(m_axis_tdata);
        got_cnt <= got_cnt + 1;
        if (normal_q.size() == 0) begin
          $display("%0t: unexpected normal x=%h y=%h z=%h", $time, got.nx, got.ny, got.nz);
          err_cnt <= err_cnt + 1;
        end else begin
          exp_n = normal_q.pop_front();
          if (got !== exp_n) begin
            $display("%0t: normal mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                     $time, exp_n.nx, exp_n.ny, exp_n.nz, got.nx, got.ny, got.nz);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_sample(input logic [15:0] ua, input logic [15:0] up);
    sample_t s;
    s.u_azimuth = ua;
    s.u_polar = up;
    sample_q.push_back(s);
  endtask

  // let the pipeline drain fully before touching the register
  task automatic drain();
    while (sample_q.size() > 0 || s_axis_tvalid || normal_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic set_alpha(input logic [15:0] a);
    @(posedge clk);
    roughness_wr_en   <= 1;
    roughness_wr_data <= a;
    alpha_q = a;
    @(posedge clk);
    roughness_wr_en   <= 0;
  endtask

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: queue_sample(16'($urandom), 16'hFFFF - 16'($urandom_range(15)));
        1: queue_sample({2'($urandom_range(3)), 14'h0} + 16'($urandom_range(3)),
                        16'($urandom));
        default: queue_sample(16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [15:0] alphas [8];
    alphas = '{16'h2000, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000,
               16'h0800, 16'h8000, 16'h1234};
    rst = 1;
    roughness_wr_en = 0;
    roughness_wr_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    m_axis_tready = 0;
    alpha_q = gns_pkg::ROUGH_RESET;
    err_cnt = 0;
    got_cnt = 0;
    sent_cnt = 0;
    send_idle_pct = 8;
    recv_idle_pct = 65;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: reset roughness, field extremes and quadrant boundaries
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'hFFFF, 16'hFFFF);
    queue_sample(16'h4000, 16'h8000);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'hC000, 16'h8000);
    queue_sample(16'h3FFF, 16'h7FFF);
    queue_sample(16'h7FFF, 16'hFFFE);
    queue_sample(16'hBFFF, 16'h0001);
    queue_sample(16'hFFFF, 16'h0000);
    queue_sample(16'h5555, 16'hAAAA);
    queue_sample(16'hAAAA, 16'h5555);
    drain();
    // zero roughness: straight-up normals
    set_alpha(16'h0000);
    queue_sample(16'h1234, 16'hFFFF);
    queue_sample(16'hC000, 16'h8000);
    drain();
    // maximum roughness: tilts toward the horizon, magnitudes near one
    set_alpha(16'hFFFF);
    queue_sample(16'h0000, 16'hFFFF);
    queue_sample(16'h4000, 16'hFFFF);
    queue_sample(16'h8000, 16'hFFFF);
    queue_sample(16'hC000, 16'hFFFF);
    drain();

    // random phases across roughness settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      set_alpha(p < 7 ? alphas[p + 1] : 16'($urandom));
      if (p == 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 8;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_burst(205);
      drain();
    end

    $display("covered %0d samples, %0d normals checked, roughness extremes and back pressure",
             sent_cnt, got_cnt);
    if (err_cnt == 0 && normal_q.size() == 0) begin
      $display("ggx_normal_sampling_tb: clean");
    end else begin
      $display("ggx_normal_sampling_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("ggx_normal_sampling_tb: errors");
    $finish;
  end

endmodule
